// ===== src/bfnc_pkg.sv =====
// shared types and constants for the bellman-ford shortest path block
package bfnc_pkg;

	// node id width on the ports
	localparam int NODE_BITS = 6;
	// stored distance width and its saturation bounds
	localparam int DIST_BITS = 23;
	localparam int signed DIST_MAX = 4194303;
	localparam int signed DIST_MIN = -4194304;
	// reported distance width and its saturation bounds
	localparam int OUT_BITS = 22;
	localparam int signed OUT_MAX = 2097151;
	localparam int signed OUT_MIN = -2097152;

	// input commands
	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_RUN   = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// relaxation decision and the saturated candidate distance
	typedef struct packed {
		logic                        relax;
		logic signed [DIST_BITS-1:0] cand;
	} relax_res_t;

endpackage

// ===== src/bfnc_edge_mem.sv =====
// edge list memory, one write port and one registered read port
module bfnc_edge_mem #(
	parameter int DEPTH     = 256,
	parameter int ADDR_BITS = 8,
	parameter int DATA_BITS = 28
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== src/bfnc_dist_ram.sv =====
// node distance memory, one write port and two registered read ports
module bfnc_dist_ram #(
	parameter int DEPTH     = 64,
	parameter int ADDR_BITS = 6
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [ADDR_BITS-1:0]                  waddr,
	input  logic signed [bfnc_pkg::DIST_BITS-1:0] wdata,
	input  logic [ADDR_BITS-1:0]                  raddr_a,
	input  logic [ADDR_BITS-1:0]                  raddr_b,
	output logic signed [bfnc_pkg::DIST_BITS-1:0] rdata_a,
	output logic signed [bfnc_pkg::DIST_BITS-1:0] rdata_b
);
	import bfnc_pkg::*;

	logic signed [DIST_BITS-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// two registered reads
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== src/bfnc_relax_unit.sv =====
// shared relaxation unit: full-width add, compare and saturate
module bfnc_relax_unit #(
	parameter int WEIGHT_BITS = 16
) (
	input  logic signed [bfnc_pkg::DIST_BITS-1:0] tail_dist,
	input  logic signed [bfnc_pkg::DIST_BITS-1:0] head_dist,
	input  logic                                  head_reached,
	input  logic signed [WEIGHT_BITS-1:0]         weight,
	output bfnc_pkg::relax_res_t                  res
);
	import bfnc_pkg::*;

	localparam int SUM_BITS = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;

	logic signed [SUM_BITS-1:0] tail_x;
	logic signed [SUM_BITS-1:0] head_x;
	logic signed [SUM_BITS-1:0] weight_x;
	logic signed [SUM_BITS-1:0] sum;
	logic signed [SUM_BITS-1:0] sat_hi;
	logic signed [SUM_BITS-1:0] sat_lo;

	assign tail_x   = SUM_BITS'(tail_dist);
	assign head_x   = SUM_BITS'(head_dist);
	assign weight_x = SUM_BITS'(weight);
	assign sum      = tail_x + weight_x;
	assign sat_hi   = SUM_BITS'(DIST_MAX);
	assign sat_lo   = SUM_BITS'(DIST_MIN);

	// compare on the full sum, store a saturated value
	always_comb begin
		res.relax = !head_reached || (sum < head_x);
		if (sum > sat_hi) begin
			res.cand = DIST_BITS'(DIST_MAX);
		end else if (sum < sat_lo) begin
			res.cand = DIST_BITS'(DIST_MIN);
		end else begin
			res.cand = sum[DIST_BITS-1:0];
		end
	end

endmodule

// ===== src/bellman_ford_neg_cycle.sv =====
// bellman-ford shortest path engine with negative cycle check, top level
//
// Edges are loaded as items on the input stream (cmd add), one per cycle while idle, into
// an edge memory of MAX_EDGES entries; adds beyond capacity are dropped and flagged. A run
// item sets the source (source_node register) to distance zero and walks the stored edges
// node_count-1 times in load order, relaxing in place, then once more as a check pass. All
// edge work goes through one relaxation unit under a small sequencer: per edge it reads the
// edge memory, then reads both endpoint distances, then compares and writes back; an edge is
// skipped after the distance read when its tail is unreached or an endpoint is out of range.
// Each pass closes with an extra sequencer step. The result items follow, with any wait on
// the output side. The result is either one negative-cycle item or one item per node. The
// input side is not ready during a run; the final result may wait in the output register
// while the next items are accepted. No clearing pass is needed after reset.
module bellman_ford_neg_cycle #(
	parameter int MAX_NODES   = 64,
	parameter int MAX_EDGES   = 256,
	parameter int WEIGHT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream: cmd[1:0], edge_from[7:2], edge_to[13:8], edge_weight[29:14]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	// result stream: node_index[5:0], distance[27:6], reachable[28],
	// negative_cycle[29], edges_dropped[30]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic        m_tlast,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bfnc_pkg::*;

	localparam int EAW        = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW        = $clog2(MAX_EDGES + 1);
	localparam int NAW        = $clog2(MAX_NODES);
	localparam int EDGE_BITS  = 2 * NODE_BITS + WEIGHT_BITS;
	localparam logic REG_SOURCE = 1'b0;
	localparam logic REG_COUNT  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE_RD,
		ST_DIST_RD,
		ST_RELAX,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_NEG
	} state_t;

	state_t state_q;

	logic [NODE_BITS-1:0] source_q;
	logic [6:0]           count_q;
	logic [ECW-1:0]       edge_total_q;
	logic                 dropped_q;
	logic [MAX_NODES-1:0] reached_q;
	logic [6:0]           pass_q;
	logic [ECW-1:0]       edge_idx_q;
	logic [NODE_BITS-1:0] node_idx_q;
	logic                 neg_q;
	logic                 out_valid_q;
	logic [31:0]          out_data_q;
	logic                 out_last_q;

	// input fields
	cmd_t                          in_cmd;
	logic [NODE_BITS-1:0]          in_from;
	logic [NODE_BITS-1:0]          in_to;
	logic signed [WEIGHT_BITS-1:0] in_weight;
	logic                          in_accept;

	assign in_cmd    = cmd_t'(s_tdata[1:0]);
	assign in_from   = s_tdata[7:2];
	assign in_to     = s_tdata[13:8];
	assign in_accept = s_tvalid && s_tready;

	// weight uses the low WEIGHT_BITS bits, sign-extended when wider than the field
	generate
		if (WEIGHT_BITS <= 16) begin : g_wt_narrow
			assign in_weight = s_tdata[14+WEIGHT_BITS-1:14];
		end else begin : g_wt_wide
			assign in_weight = WEIGHT_BITS'($signed(s_tdata[29:14]));
		end
	endgenerate

	// effective node count, clamped to 1..MAX_NODES
	logic [6:0] n_eff;
	always_comb begin
		if (count_q == 7'd0) begin
			n_eff = 7'd1;
		end else if (count_q > 7'(MAX_NODES)) begin
			n_eff = 7'(MAX_NODES);
		end else begin
			n_eff = count_q;
		end
	end

	// configuration writes and reads
	logic cfg_write;
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q <= '0;
			count_q  <= 7'd64;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_SOURCE: source_q <= pwdata[NODE_BITS-1:0];
				REG_COUNT:  count_q  <= pwdata[6:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SOURCE: prdata = {{(32-NODE_BITS){1'b0}}, source_q};
			REG_COUNT:  prdata = {25'd0, count_q};
			default:    prdata = '0;
		endcase
	end

	// edge memory
	logic                 edge_we;
	logic [EDGE_BITS-1:0] edge_rd;

	assign edge_we = in_accept && (in_cmd == CMD_ADD) && (edge_total_q < ECW'(MAX_EDGES));

	bfnc_edge_mem #(
		.DEPTH     (MAX_EDGES),
		.ADDR_BITS (EAW),
		.DATA_BITS (EDGE_BITS)
	) u_edge_mem (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_total_q[EAW-1:0]),
		.wdata ({in_weight, in_to, in_from}),
		.raddr (edge_idx_q[EAW-1:0]),
		.rdata (edge_rd)
	);

	// fields of the edge under work
	logic [NODE_BITS-1:0]          e_from;
	logic [NODE_BITS-1:0]          e_to;
	logic signed [WEIGHT_BITS-1:0] e_weight;
	assign e_from   = edge_rd[NODE_BITS-1:0];
	assign e_to     = edge_rd[2*NODE_BITS-1:NODE_BITS];
	assign e_weight = edge_rd[EDGE_BITS-1:2*NODE_BITS];

	logic from_ok;
	logic to_ok;
	logic edge_skip;
	assign from_ok   = 7'(e_from) < n_eff;
	assign to_ok     = 7'(e_to) < n_eff;
	assign edge_skip = !from_ok || !to_ok || !reached_q[e_from[NAW-1:0]];

	// distance memory
	logic                        relax_we;
	logic                        init_we;
	logic                        dist_we;
	logic [NAW-1:0]              dist_waddr;
	logic signed [DIST_BITS-1:0] dist_wdata;
	logic [NAW-1:0]              dist_raddr_a;
	logic signed [DIST_BITS-1:0] dist_a;
	logic signed [DIST_BITS-1:0] dist_b;
	relax_res_t                  relax_res;
	logic                        check_pass;

	assign check_pass   = pass_q == n_eff;
	assign dist_raddr_a = (state_q == ST_DIST_RD) ? e_from[NAW-1:0] : node_idx_q[NAW-1:0];
	assign relax_we     = (state_q == ST_RELAX) && relax_res.relax && !check_pass;
	// a run starts with the source at distance zero
	assign init_we      = in_accept && (in_cmd == CMD_RUN);
	assign dist_we      = relax_we || init_we;
	assign dist_waddr   = relax_we ? e_to[NAW-1:0] : source_q[NAW-1:0];
	assign dist_wdata   = relax_we ? relax_res.cand : '0;

	bfnc_dist_ram #(
		.DEPTH     (MAX_NODES),
		.ADDR_BITS (NAW)
	) u_dist_ram (
		.clk     (clk),
		.we      (dist_we),
		.waddr   (dist_waddr),
		.wdata   (dist_wdata),
		.raddr_a (dist_raddr_a),
		.raddr_b (e_to[NAW-1:0]),
		.rdata_a (dist_a),
		.rdata_b (dist_b)
	);

	bfnc_relax_unit #(
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_relax (
		.tail_dist    (dist_a),
		.head_dist    (dist_b),
		.head_reached (reached_q[e_to[NAW-1:0]]),
		.weight       (e_weight),
		.res          (relax_res)
	);

	// reported distance for the node being emitted
	logic                       emit_reached;
	logic signed [OUT_BITS-1:0] emit_dist;
	assign emit_reached = reached_q[node_idx_q[NAW-1:0]];

	always_comb begin
		if (!emit_reached) begin
			emit_dist = '1;
		end else if (dist_a > DIST_BITS'(OUT_MAX)) begin
			emit_dist = OUT_BITS'(OUT_MAX);
		end else if (dist_a < DIST_BITS'(OUT_MIN)) begin
			emit_dist = OUT_BITS'(OUT_MIN);
		end else begin
			emit_dist = dist_a[OUT_BITS-1:0];
		end
	end

	logic out_load;
	assign out_load = (state_q == ST_EMIT_LD) || ((state_q == ST_NEG) && !out_valid_q);

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// sequencer with edge list bookkeeping and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			edge_total_q <= '0;
			dropped_q    <= 1'b0;
			reached_q    <= '0;
			pass_q       <= '0;
			edge_idx_q   <= '0;
			node_idx_q   <= '0;
			neg_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			// output register drains independently of the sequencer
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						case (in_cmd)
							CMD_CLEAR: begin
								edge_total_q <= '0;
								dropped_q    <= 1'b0;
							end
							CMD_ADD: begin
								if (edge_we) begin
									edge_total_q <= edge_total_q + 1'b1;
								end else begin
									dropped_q <= 1'b1;
								end
							end
							CMD_RUN: begin
								if (7'(source_q) < n_eff) begin
									reached_q <= MAX_NODES'(1) << source_q[NAW-1:0];
								end else begin
									reached_q <= '0;
								end
								pass_q     <= 7'd1;
								edge_idx_q <= '0;
								neg_q      <= 1'b0;
								state_q    <= ST_EDGE_RD;
							end
							default: ;
						endcase
					end
				end
				// fetch the next edge or close the pass
				ST_EDGE_RD: begin
					if (edge_idx_q == edge_total_q) begin
						edge_idx_q <= '0;
						if (check_pass) begin
							node_idx_q <= '0;
							state_q    <= neg_q ? ST_NEG : ST_EMIT_RD;
						end else begin
							pass_q <= pass_q + 7'd1;
						end
					end else begin
						state_q <= ST_DIST_RD;
					end
				end
				// endpoint distances are read here; a skipped edge goes back to the edge fetch
				ST_DIST_RD: begin
					if (edge_skip) begin
						edge_idx_q <= edge_idx_q + 1'b1;
						state_q    <= ST_EDGE_RD;
					end else begin
						state_q <= ST_RELAX;
					end
				end
				// compare and write back, or note a relaxation in the check pass
				ST_RELAX: begin
					if (relax_res.relax) begin
						if (check_pass) begin
							neg_q <= 1'b1;
						end else begin
							reached_q[e_to[NAW-1:0]] <= 1'b1;
						end
					end
					edge_idx_q <= edge_idx_q + 1'b1;
					state_q    <= ST_EDGE_RD;
				end
				// read the node distance once the output register is free
				ST_EMIT_RD: begin
					if (!out_valid_q) begin
						state_q <= ST_EMIT_LD;
					end
				end
				ST_EMIT_LD: begin
					out_valid_q <= 1'b1;
					out_data_q  <= {1'b0, dropped_q, 1'b0, emit_reached, emit_dist, node_idx_q};
					out_last_q  <= 7'(node_idx_q) == (n_eff - 7'd1);
					if (7'(node_idx_q) == (n_eff - 7'd1)) begin
						state_q <= ST_IDLE;
					end else begin
						node_idx_q <= node_idx_q + 1'b1;
						state_q    <= ST_EMIT_RD;
					end
				end
				// single negative cycle item
				ST_NEG: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {1'b0, dropped_q, 1'b1, 1'b0, {OUT_BITS{1'b0}},
							{NODE_BITS{1'b0}}};
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// no distance is relaxed during the check pass
	a_no_write_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		relax_we |-> !check_pass)
		else $error("distance written during check pass");

	// a result is loaded only into an empty output register
	a_load_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q)
		else $error("output register overwritten");

	// the edge count never passes capacity
	a_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		edge_total_q <= ECW'(MAX_EDGES))
		else $error("edge count beyond capacity");

	// a negative cycle item is always the last of its run
	a_neg_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[29]) |-> m_tlast)
		else $error("negative cycle item not marked last");

endmodule

// ===== verif/bfnc_checker.sv =====
// result checker for bellman_ford_neg_cycle: shortest path predictor and item compare
module bfnc_checker
	import bfnc_pkg::*;
#(
	parameter int         MAX_NODES   = 64,
	parameter int         MAX_EDGES   = 256,
	parameter logic [2:0] SOURCE_ADDR = 3'd0,
	parameter logic [2:0] COUNT_ADDR  = 3'd4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// cmd[1:0], edge_from[7:2], edge_to[13:8], edge_weight[29:14]
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// node_index[5:0], distance[27:6], reachable[28], negative_cycle[29], edges_dropped[30]
	input  logic [31:0] m_tdata,
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatch_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// one expected result item
	typedef struct {
		logic [NODE_BITS-1:0]       node;
		logic signed [OUT_BITS-1:0] distance;
		logic                       reached;
		logic                       neg_cycle;
		logic                       dropped;
		logic                       last;
	} dist_report_t;

	dist_report_t         dist_report_q[$];
	dist_report_t         oldest;
	logic [NODE_BITS-1:0] edge_tail [MAX_EDGES];
	logic [NODE_BITS-1:0] edge_head [MAX_EDGES];
	logic signed [15:0]   edge_weight [MAX_EDGES];
	int                   edge_cnt;
	logic                 drop_flag;
	logic [5:0]           source_reg;
	logic [6:0]           count_reg;
	longint               node_dist [MAX_NODES];
	logic                 node_seen [MAX_NODES];

	// append one expected item at the back of the queue
	function automatic void queue_report(dist_report_t rep);
		dist_report_q.insert(dist_report_q.size(), rep);
	endfunction

	// one sweep over the edge list in load order; returns 1 if any edge relaxed
	function automatic logic relax_pass(int n, logic commit);
		logic   changed;
		longint sum;
		int     u;
		int     v;
		changed = 1'b0;
		for (int i = 0; i < edge_cnt; i++) begin
			u = int'(edge_tail[i]);
			v = int'(edge_head[i]);
			if (u < n && v < n && node_seen[u]) begin
				sum = node_dist[u] + longint'(edge_weight[i]);
				if (!node_seen[v] || sum < node_dist[v]) begin
					changed = 1'b1;
					if (commit) begin
						node_dist[v] = (sum < DIST_MIN) ? DIST_MIN :
							(sum > DIST_MAX) ? DIST_MAX : sum;
						node_seen[v] = 1'b1;
					end
				end
			end
		end
		return changed;
	endfunction

	// full run: n-1 relaxing passes, a check pass, then the result items
	function automatic void predict_run();
		int           n;
		logic         neg;
		longint       d;
		dist_report_t r;
		n = (count_reg == 0) ? 1 : (count_reg > MAX_NODES) ? MAX_NODES : int'(count_reg);
		for (int i = 0; i < MAX_NODES; i++) begin
			node_dist[i] = 0;
			node_seen[i] = 1'b0;
		end
		if (source_reg < n)
			node_seen[source_reg] = 1'b1;
		for (int p = 1; p < n; p++)
			void'(relax_pass(n, 1'b1));
		neg = relax_pass(n, 1'b0);
		if (neg) begin
			r.node      = '0;
			r.distance  = '0;
			r.reached   = 1'b0;
			r.neg_cycle = 1'b1;
			r.dropped   = drop_flag;
			r.last      = 1'b1;
			queue_report(r);
		end else begin
			for (int i = 0; i < n; i++) begin
				if (node_seen[i])
					d = (node_dist[i] < OUT_MIN) ? OUT_MIN :
						(node_dist[i] > OUT_MAX) ? OUT_MAX : node_dist[i];
				else
					d = -1;
				r.node      = i[NODE_BITS-1:0];
				r.distance  = d[OUT_BITS-1:0];
				r.reached   = node_seen[i];
				r.neg_cycle = 1'b0;
				r.dropped   = drop_flag;
				r.last      = (i == n - 1);
				queue_report(r);
			end
		end
	endfunction

	task automatic check_field(string name, longint expv, longint actv);
		if (expv != actv) begin
			$error("%s: expected %0d, got %0d", name, expv, actv);
			mismatch_count++;
		end
	endtask

	// watch register writes, results and input items at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_report_q.delete();
			edge_cnt       = 0;
			drop_flag      = 1'b0;
			source_reg     = '0;
			count_reg      = 7'd64;
			mismatch_count = 0;
			pending        = 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr == SOURCE_ADDR)
					source_reg = pwdata[5:0];
				else if (paddr == COUNT_ADDR)
					count_reg = pwdata[6:0];
			end
			// result items against the oldest expectation
			if (m_tvalid && m_tready) begin
				if (dist_report_q.size() == 0) begin
					$error("result item with none expected: node_index %0d, tdata %h",
						m_tdata[5:0], m_tdata);
					mismatch_count++;
				end else begin
					oldest = dist_report_q.pop_front();
					check_field("node_index", longint'(oldest.node),
						longint'(m_tdata[5:0]));
					check_field("distance", longint'(oldest.distance),
						longint'($signed(m_tdata[27:6])));
					check_field("reachable", longint'(oldest.reached),
						longint'(m_tdata[28]));
					check_field("negative_cycle", longint'(oldest.neg_cycle),
						longint'(m_tdata[29]));
					check_field("edges_dropped", longint'(oldest.dropped),
						longint'(m_tdata[30]));
					check_field("last", longint'(oldest.last), longint'(m_tlast));
				end
			end
			// input items
			if (s_tvalid && s_tready) begin
				case (cmd_t'(s_tdata[1:0]))
				CMD_CLEAR: begin
					edge_cnt  = 0;
					drop_flag = 1'b0;
				end
				CMD_ADD: begin
					if (edge_cnt < MAX_EDGES) begin
						edge_tail[edge_cnt]   = s_tdata[7:2];
						edge_head[edge_cnt]   = s_tdata[13:8];
						edge_weight[edge_cnt] = s_tdata[29:14];
						edge_cnt++;
					end else begin
						drop_flag = 1'b1;
					end
				end
				CMD_RUN: begin
					predict_run();
				end
				default: begin
				end
				endcase
			end
			pending = dist_report_q.size();
		end
	end

endmodule

// ===== verif/bellman_ford_neg_cycle_tb.sv =====
// testbench top for bellman_ford_neg_cycle: stimulus, register setup and verdict
module bellman_ford_neg_cycle_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bfnc_pkg::*;

	localparam int         MAX_NODES     = 64;
	localparam int         MAX_EDGES     = 256;
	localparam int         WEIGHT_BITS   = 16;
	localparam logic [2:0] SOURCE_ADDR   = 3'd0;
	localparam logic [2:0] COUNT_ADDR    = 3'd4;
	localparam int         SETTLE_CYCLES = 8;
	localparam int         END_CYCLES    = 64;
	localparam int         RANDOM_ITEMS  = 100;
	// hard stop time in ns; the two full-store runs dominate the slowest correct run
	localparam int         TIMEOUT_NS    = 10_000_000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	// cmd[1:0], edge_from[7:2], edge_to[13:8], edge_weight[29:14]
	logic [31:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	// node_index[5:0], distance[27:6], reachable[28], negative_cycle[29], edges_dropped[30]
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;
	int          mismatch_count;
	int          pending;
	int          send_idle_pct = 0;
	int          stall_pct     = 0;
	logic [6:0]  cur_count     = 7'd64;

	bellman_ford_neg_cycle #(
		.MAX_NODES  (MAX_NODES),
		.MAX_EDGES  (MAX_EDGES),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	bfnc_checker #(
		.MAX_NODES  (MAX_NODES),
		.MAX_EDGES  (MAX_EDGES),
		.SOURCE_ADDR(SOURCE_ADDR),
		.COUNT_ADDR (COUNT_ADDR)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.mismatch_count(mismatch_count),
		.pending       (pending)
	);

	// clock
	always #4 clk = ~clk;

	// result side back-pressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// hard stop
	initial begin
		#(TIMEOUT_NS);
		$display("bellman_ford_neg_cycle_tb: FAIL");
		$finish;
	end

	function automatic int eff_nodes(logic [6:0] c);
		return (c == 0) ? 1 : (c > MAX_NODES) ? MAX_NODES : int'(c);
	endfunction

	// node id, mostly inside the active node range
	function automatic logic [5:0] pick_node();
		if ($urandom_range(0, 99) < 85)
			return 6'($urandom_range(0, eff_nodes(cur_count) - 1));
		return 6'($urandom_range(0, 63));
	endfunction

	// weight mix: small positive, small signed, full range and extremes
	function automatic logic [15:0] pick_weight();
		case ($urandom_range(0, 19))
		0: begin
			return 16'h8000;
		end
		1: begin
			return 16'h7FFF;
		end
		2, 3: begin
			return 16'($urandom_range(0, 65535));
		end
		4, 5, 6, 7, 8: begin
			return 16'($urandom_range(0, 120) - 60);
		end
		default: begin
			return 16'($urandom_range(0, 300));
		end
		endcase
	endfunction

	// one item on the input stream, called and returning at a falling edge
	task automatic push_item(cmd_t cmd, logic [5:0] tail, logic [5:0] head,
		logic [15:0] weight);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, weight, head, tail, cmd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// hold the sender until every expected result item has arrived
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// apb write: setup cycle, access cycle, then back to idle
	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(logic [5:0] source, logic [6:0] count);
		wait_drained();
		write_reg(SOURCE_ADDR, {26'd0, source});
		write_reg(COUNT_ADDR, {25'd0, count});
		cur_count = count;
	endtask

	task automatic set_idle(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		stall_pct     = recv_pct;
	endtask

	initial begin
		int          random_items;
		int          seq_idx;
		int          n_add;
		logic [6:0]  cnt;
		logic [5:0]  src;
		cmd_t        cmd;

		// reset
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset config (source 0, 64 nodes), no idling
		push_item(CMD_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
		push_item(CMD_NONE, 6'd63, 6'd63, 16'hFFFF);
		// cycle 0 -> 63 -> 0 of total weight -1
		push_item(CMD_ADD, 6'd0, 6'd63, 16'h8000);
		push_item(CMD_ADD, 6'd63, 6'd0, 16'h7FFF);
		push_item(CMD_ADD, 6'd0, 6'd0, 16'h0000);
		push_item(CMD_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
		// positive cycle, an unreached tail and weight extremes
		push_item(CMD_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom));
		push_item(CMD_ADD, 6'd0, 6'd1, 16'd5);
		push_item(CMD_ADD, 6'd1, 6'd2, -16'sd3);
		push_item(CMD_ADD, 6'd2, 6'd0, 16'd7);
		push_item(CMD_ADD, 6'd3, 6'd4, 16'd1);
		push_item(CMD_ADD, 6'd1, 6'd63, 16'h7FFF);
		push_item(CMD_ADD, 6'd0, 6'd62, 16'h8000);
		push_item(CMD_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
		// negative self loop on an unreached node is not a cycle
		push_item(CMD_ADD, 6'd5, 6'd5, 16'hFFFF);
		push_item(CMD_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
		// eight nodes from source 5, endpoints outside the node range
		set_config(6'd5, 7'd8);
		push_item(CMD_ADD, 6'd5, 6'd1, -16'sd2);
		push_item(CMD_ADD, 6'd5, 6'd9, 16'd3);
		push_item(CMD_ADD, 6'd40, 6'd2, 16'd1);
		push_item(CMD_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
		// node count 0 acts as 1, source outside the range
		set_config(6'd5, 7'd0);
		push_item(CMD_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
		// node count above the maximum, top source
		set_config(6'd63, 7'd127);
		push_item(CMD_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
		set_config(6'd0, 7'd1);
		push_item(CMD_RUN, 6'($urandom), 6'($urandom), 16'($urandom));

		// full edge store, adds beyond it dropped
		set_config(6'd0, 7'd63);
		set_idle(14, 14);
		push_item(CMD_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom));
		for (int i = 0; i < MAX_EDGES - 1; i++)
			push_item(CMD_ADD, 6'($urandom_range(0, 62)), 6'($urandom_range(0, 62)),
				16'($urandom_range(0, 2000)));
		push_item(CMD_ADD, 6'd63, 6'd63, 16'hFFFF);
		repeat (4) push_item(CMD_ADD, 6'($urandom), 6'($urandom), 16'($urandom));
		push_item(CMD_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
		// node 63 now in range and reached: its negative self loop shows
		set_config(6'd63, 7'd64);
		push_item(CMD_RUN, 6'($urandom), 6'($urandom), 16'($urandom));

		// random: mostly clear / edges / run sequences, some noise
		random_items = 0;
		seq_idx      = 0;
		while (random_items < RANDOM_ITEMS) begin
			case (random_items * 4 / RANDOM_ITEMS)
			0: begin
				set_idle(0, 0);
			end
			1: begin
				set_idle(78, 0);
			end
			2: begin
				set_idle(0, 78);
			end
			default: begin
				set_idle(14, 14);
			end
			endcase
			if (seq_idx % 3 == 0) begin
				case ($urandom_range(0, 9))
				0: begin
					cnt = 7'd0;
				end
				1: begin
					cnt = 7'd127;
				end
				2: begin
					cnt = 7'd64;
				end
				3: begin
					cnt = 7'd1;
				end
				default: begin
					cnt = 7'($urandom_range(2, 12));
				end
				endcase
				if ($urandom_range(0, 9) == 0)
					src = 6'($urandom_range(0, 63));
				else
					src = 6'($urandom_range(0, eff_nodes(cnt) - 1));
				set_config(src, cnt);
			end
			if ($urandom_range(0, 99) < 80) begin
				if ($urandom_range(0, 4) != 0) begin
					push_item(CMD_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom));
					random_items++;
				end
				n_add = $urandom_range(0, 10);
				repeat (n_add) begin
					push_item(CMD_ADD, pick_node(), pick_node(), pick_weight());
					random_items++;
				end
				push_item(CMD_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
				random_items++;
			end else begin
				cmd = cmd_t'($urandom_range(0, 3));
				push_item(cmd, 6'($urandom), 6'($urandom), 16'($urandom));
				if (cmd != CMD_NONE)
					random_items++;
			end
			seq_idx++;
		end

		// drain and verdict
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (END_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && pending == 0)
			$display("bellman_ford_neg_cycle_tb: PASS");
		else
			$display("bellman_ford_neg_cycle_tb: FAIL");
		$finish;
	end

endmodule
